[sv/prpt_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpt_pkg
// Shared types, constants and arithmetic helpers for the polygon rotate and
// point test core.
// ----------------------------------------------------------------------------
package prpt_pkg;

  localparam int MAX_VERTICES_DEF = 16;

  localparam int COORD_W    = 20;
  localparam int TRIG_W     = 16;
  localparam int CFG_DATA_W = 20;
  localparam int DIFF_W     = COORD_W + 1;
  localparam int PROD_W     = 2 * DIFF_W;
  localparam int COMB_W     = PROD_W + 1;
  localparam int TRIG_SHIFT = 14;
  localparam int RT_W       = COMB_W + 1 - TRIG_SHIFT;
  localparam int ROT_SUM_W  = RT_W + 1;
  localparam int AREA_SHIFT = 9;
  localparam int CNT_OUT_W  = 5;
  localparam int STEP_W     = 3;

  localparam logic [COMB_W:0] ROUND_BIAS = (COMB_W + 1)'(1 << (TRIG_SHIFT - 1));
  localparam logic signed [COORD_W-1:0] COORD_MAX = {1'b0, {(COORD_W - 1){1'b1}}};
  localparam logic signed [COORD_W-1:0] COORD_MIN = {1'b1, {(COORD_W - 1){1'b0}}};

  typedef enum logic [1:0] {
    ACT_CLEAR   = 2'd0,
    ACT_APPEND  = 2'd1,
    ACT_ADVANCE = 2'd2,
    ACT_QUERY   = 2'd3
  } act_t;

  typedef enum logic [1:0] {
    STAT_OK    = 2'd0,
    STAT_FULL  = 2'd1,
    STAT_EMPTY = 2'd2
  } stat_t;

  typedef enum logic [1:0] {
    CFG_ROT_COS = 2'd0,
    CFG_ROT_SIN = 2'd1,
    CFG_STEP_X  = 2'd2,
    CFG_STEP_Y  = 2'd3
  } cfg_idx_t;

  typedef enum logic {
    MUL_SUB = 1'b0,
    MUL_ADD = 1'b1
  } mul_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_ADV_RD,
    S_ADV_X,
    S_ADV_Y,
    S_ADV_XR,
    S_ADV_YR,
    S_ADV_CTR,
    S_Q_RD0,
    S_Q_FIRST,
    S_Q_RD,
    S_Q_LOAD,
    S_Q_EDGE,
    S_Q_MUL,
    S_FINISH
  } state_t;

  typedef struct packed {
    act_t                      action;
    logic signed [COORD_W-1:0] pos_x;
    logic signed [COORD_W-1:0] pos_y;
  } cmd_item_t;

  typedef struct packed {
    logic                 inside_res;
    logic [CNT_OUT_W-1:0] count_now;
    stat_t                status;
  } res_item_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
  } vertex_t;

  localparam int VERTEX_W = $bits(vertex_t);

  typedef struct packed {
    mul_op_t                  op;
    logic signed [DIFF_W-1:0] a1;
    logic signed [DIFF_W-1:0] b1;
    logic signed [DIFF_W-1:0] a2;
    logic signed [DIFF_W-1:0] b2;
  } mul_req_t;

  function automatic logic signed [DIFF_W-1:0] coord_diff(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return {a[COORD_W-1], a} - {b[COORD_W-1], b};
  endfunction

  function automatic logic signed [DIFF_W-1:0] coord_add(
    input logic signed [COORD_W-1:0] a,
    input logic signed [COORD_W-1:0] b
  );
    return {a[COORD_W-1], a} + {b[COORD_W-1], b};
  endfunction

  function automatic logic signed [DIFF_W-1:0] trig_ext(input logic signed [TRIG_W-1:0] v);
    return {{(DIFF_W - TRIG_W){v[TRIG_W-1]}}, v};
  endfunction

  function automatic logic signed [RT_W-1:0] round_trig(input logic signed [COMB_W-1:0] v);
    logic [COMB_W:0] t;
    t = {v[COMB_W-1], v} + ROUND_BIAS;
    return t[COMB_W:TRIG_SHIFT];
  endfunction

  function automatic logic signed [COORD_W-1:0] sat_coord(
    input logic signed [ROT_SUM_W-1:0] v
  );
    logic fits;
    fits = (&v[ROT_SUM_W-1:COORD_W-1]) | ~(|v[ROT_SUM_W-1:COORD_W-1]);
    if (fits) begin
      return v[COORD_W-1:0];
    end
    return v[ROT_SUM_W-1] ? COORD_MIN : COORD_MAX;
  endfunction

  function automatic logic [COMB_W-1:0] abs_comb(input logic signed [COMB_W-1:0] v);
    return v[COMB_W-1] ? -v : v;
  endfunction

endpackage

[sv/polygon_rotate_and_point_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polygon_rotate_and_point_test_core
// Polygon vertex store with rotate and translate and a fan-triangle point test.
// ----------------------------------------------------------------------------
// The block handles one item at a time and accepts the next item as soon as
// its sequencer is idle, even while the previous result still waits at the
// output register. Advance rotates every stored vertex and then moves the
// center, and query walks the edges until one hits, skipping an edge whose
// ends coincide without the cross products. The pace is set by the vertex
// memory, which gives one read per cycle with a registered read, and by the
// shared two-multiplier unit, which every rotation and every cross product
// passes through with its products and then their sum or difference
// registered. The vertex memory needs no clearing pass after reset; reset
// only empties the count.
module polygon_rotate_and_point_test_core #(
  parameter int MAX_VERTICES = prpt_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cmd_valid,
  output logic                               cmd_stall,
  input  prpt_pkg::cmd_item_t                cmd_item,
  output logic                               res_valid,
  input  logic                               res_stall,
  output prpt_pkg::res_item_t                res_item,
  input  logic                               cfg_we,
  input  prpt_pkg::cfg_idx_t                 cfg_index,
  input  logic [prpt_pkg::CFG_DATA_W-1:0]    cfg_wdata
);

  localparam int IDX_W = $clog2(MAX_VERTICES);
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_VERTICES);

  prpt_pkg::state_t    state, state_next;
  prpt_pkg::cmd_item_t cmd_r;

  logic [CNT_W-1:0] total;
  logic [CNT_W-1:0] e;
  logic [CNT_W-1:0] e_inc;
  logic [prpt_pkg::STEP_W-1:0] step;

  logic signed [prpt_pkg::COORD_W-1:0] center_x, center_y;
  logic signed [prpt_pkg::TRIG_W-1:0]  rot_cos, rot_sin;
  logic signed [prpt_pkg::COORD_W-1:0] step_x, step_y;

  prpt_pkg::vertex_t first_v, a_v, b_v, rd_v;
  logic signed [prpt_pkg::DIFF_W-1:0]  dx, dy, dx_r, dy_r;
  logic signed [prpt_pkg::DIFF_W-1:0]  ox, oy;
  logic signed [prpt_pkg::DIFF_W-1:0]  cos_x, sin_x;
  logic signed [prpt_pkg::COORD_W-1:0] nx_r, rot_sat;
  logic signed [prpt_pkg::RT_W-1:0]    rt;
  logic signed [prpt_pkg::ROT_SUM_W-1:0] rot_sum;
  logic signed [prpt_pkg::DIFF_W-1:0]  rot_off;

  logic [prpt_pkg::COMB_W-1:0] acc, abs_res;
  logic                        hit, skip, more, room;
  logic                        inside_r;
  prpt_pkg::stat_t             status_r;
  logic                        res_load;
  logic [CNT_W+prpt_pkg::CNT_OUT_W-1:0] cnt_ext;

  logic                          mem_we, mem_re;
  logic [IDX_W-1:0]              mem_waddr, mem_raddr;
  logic [prpt_pkg::VERTEX_W-1:0] mem_wdata, mem_rdata;

  prpt_pkg::mul_req_t                  mul_req;
  logic signed [prpt_pkg::COMB_W-1:0]  mul_res;

  prpt_vertex_mem #(
    .DEPTH (MAX_VERTICES),
    .WIDTH (prpt_pkg::VERTEX_W)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  prpt_mul2 u_mul (
    .clk (clk),
    .req (mul_req),
    .res (mul_res)
  );

  assign rd_v      = prpt_pkg::vertex_t'(mem_rdata);
  assign cmd_stall = rst || (state != prpt_pkg::S_IDLE);
  assign e_inc     = e + CNT_W'(1);
  assign more      = (e_inc < total);
  assign room      = (total < MAX_CNT);
  assign res_load  = (state == prpt_pkg::S_FINISH) && (!res_valid || !res_stall);
  assign cnt_ext   = {{prpt_pkg::CNT_OUT_W{1'b0}}, total};

  assign dx    = prpt_pkg::coord_diff(rd_v.x, center_x);
  assign dy    = prpt_pkg::coord_diff(rd_v.y, center_y);
  assign ox    = prpt_pkg::coord_add(center_x, step_x);
  assign oy    = prpt_pkg::coord_add(center_y, step_y);
  assign cos_x = prpt_pkg::trig_ext(rot_cos);
  assign sin_x = prpt_pkg::trig_ext(rot_sin);

  assign rt      = prpt_pkg::round_trig(mul_res);
  assign rot_off = (state == prpt_pkg::S_ADV_XR) ? ox : oy;
  assign rot_sum = {rt[prpt_pkg::RT_W-1], rt}
                 + {{(prpt_pkg::ROT_SUM_W - prpt_pkg::DIFF_W){rot_off[prpt_pkg::DIFF_W-1]}},
                    rot_off};
  assign rot_sat = prpt_pkg::sat_coord(rot_sum);

  assign abs_res = prpt_pkg::abs_comb(mul_res);
  assign hit     = (acc[prpt_pkg::COMB_W-1:prpt_pkg::AREA_SHIFT]
                    == abs_res[prpt_pkg::COMB_W-1:prpt_pkg::AREA_SHIFT]);
  assign skip    = (a_v == b_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      rot_cos <= prpt_pkg::TRIG_W'(16384);
      rot_sin <= '0;
      step_x  <= '0;
      step_y  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        prpt_pkg::CFG_ROT_COS: rot_cos <= cfg_wdata[prpt_pkg::TRIG_W-1:0];
        prpt_pkg::CFG_ROT_SIN: rot_sin <= cfg_wdata[prpt_pkg::TRIG_W-1:0];
        prpt_pkg::CFG_STEP_X:  step_x  <= cfg_wdata[prpt_pkg::COORD_W-1:0];
        prpt_pkg::CFG_STEP_Y:  step_y  <= cfg_wdata[prpt_pkg::COORD_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prpt_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      prpt_pkg::S_IDLE: begin
        if (cmd_valid) begin
          state_next = prpt_pkg::S_EXEC;
        end
      end
      prpt_pkg::S_EXEC: begin
        unique case (cmd_r.action)
          prpt_pkg::ACT_CLEAR:   state_next = prpt_pkg::S_FINISH;
          prpt_pkg::ACT_APPEND:  state_next = prpt_pkg::S_FINISH;
          prpt_pkg::ACT_ADVANCE: state_next = (total == '0) ? prpt_pkg::S_ADV_CTR
                                                            : prpt_pkg::S_ADV_RD;
          prpt_pkg::ACT_QUERY:   state_next = (total == '0) ? prpt_pkg::S_FINISH
                                                            : prpt_pkg::S_Q_RD0;
        endcase
      end
      prpt_pkg::S_ADV_RD:  state_next = prpt_pkg::S_ADV_X;
      prpt_pkg::S_ADV_X:   state_next = prpt_pkg::S_ADV_Y;
      prpt_pkg::S_ADV_Y:   state_next = prpt_pkg::S_ADV_XR;
      prpt_pkg::S_ADV_XR:  state_next = prpt_pkg::S_ADV_YR;
      prpt_pkg::S_ADV_YR:  state_next = more ? prpt_pkg::S_ADV_X : prpt_pkg::S_ADV_CTR;
      prpt_pkg::S_ADV_CTR: state_next = prpt_pkg::S_FINISH;
      prpt_pkg::S_Q_RD0:   state_next = prpt_pkg::S_Q_FIRST;
      prpt_pkg::S_Q_FIRST: state_next = prpt_pkg::S_Q_RD;
      prpt_pkg::S_Q_RD:    state_next = prpt_pkg::S_Q_LOAD;
      prpt_pkg::S_Q_LOAD:  state_next = prpt_pkg::S_Q_EDGE;
      prpt_pkg::S_Q_EDGE: begin
        if (!skip) begin
          state_next = prpt_pkg::S_Q_MUL;
        end else begin
          state_next = more ? prpt_pkg::S_Q_RD : prpt_pkg::S_FINISH;
        end
      end
      prpt_pkg::S_Q_MUL: begin
        if (step == prpt_pkg::STEP_W'(5)) begin
          state_next = (hit || !more) ? prpt_pkg::S_FINISH : prpt_pkg::S_Q_RD;
        end
      end
      prpt_pkg::S_FINISH: begin
        if (res_load) begin
          state_next = prpt_pkg::S_IDLE;
        end
      end
      default: state_next = prpt_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = e[IDX_W-1:0];
    mem_wdata  = {nx_r, rot_sat};
    mem_re     = 1'b0;
    mem_raddr  = e_inc[IDX_W-1:0];
    mul_req.op = prpt_pkg::MUL_SUB;
    mul_req.a1 = '0;
    mul_req.b1 = '0;
    mul_req.a2 = '0;
    mul_req.b2 = '0;
    unique case (state)
      prpt_pkg::S_EXEC: begin
        if (cmd_r.action == prpt_pkg::ACT_APPEND && room) begin
          mem_we    = 1'b1;
          mem_waddr = total[IDX_W-1:0];
          mem_wdata = {cmd_r.pos_x, cmd_r.pos_y};
        end
      end
      prpt_pkg::S_ADV_RD, prpt_pkg::S_Q_RD0: begin
        mem_re    = 1'b1;
        mem_raddr = '0;
      end
      prpt_pkg::S_ADV_X: begin
        mul_req.op = prpt_pkg::MUL_SUB;
        mul_req.a1 = dx;
        mul_req.b1 = cos_x;
        mul_req.a2 = dy;
        mul_req.b2 = sin_x;
      end
      prpt_pkg::S_ADV_Y: begin
        mul_req.op = prpt_pkg::MUL_ADD;
        mul_req.a1 = dx_r;
        mul_req.b1 = sin_x;
        mul_req.a2 = dy_r;
        mul_req.b2 = cos_x;
      end
      prpt_pkg::S_ADV_YR: begin
        mem_we = 1'b1;
        mem_re = more;
      end
      prpt_pkg::S_Q_RD: begin
        mem_re = more;
      end
      prpt_pkg::S_Q_MUL: begin
        unique case (step)
          prpt_pkg::STEP_W'(0): begin
            mul_req.a1 = prpt_pkg::coord_diff(a_v.x, cmd_r.pos_x);
            mul_req.b1 = prpt_pkg::coord_diff(b_v.y, cmd_r.pos_y);
            mul_req.a2 = prpt_pkg::coord_diff(a_v.y, cmd_r.pos_y);
            mul_req.b2 = prpt_pkg::coord_diff(b_v.x, cmd_r.pos_x);
          end
          prpt_pkg::STEP_W'(1): begin
            mul_req.a1 = prpt_pkg::coord_diff(b_v.x, cmd_r.pos_x);
            mul_req.b1 = prpt_pkg::coord_diff(center_y, cmd_r.pos_y);
            mul_req.a2 = prpt_pkg::coord_diff(b_v.y, cmd_r.pos_y);
            mul_req.b2 = prpt_pkg::coord_diff(center_x, cmd_r.pos_x);
          end
          prpt_pkg::STEP_W'(2): begin
            mul_req.a1 = prpt_pkg::coord_diff(a_v.x, cmd_r.pos_x);
            mul_req.b1 = prpt_pkg::coord_diff(center_y, cmd_r.pos_y);
            mul_req.a2 = prpt_pkg::coord_diff(a_v.y, cmd_r.pos_y);
            mul_req.b2 = prpt_pkg::coord_diff(center_x, cmd_r.pos_x);
          end
          prpt_pkg::STEP_W'(3): begin
            mul_req.a1 = prpt_pkg::coord_diff(b_v.x, a_v.x);
            mul_req.b1 = prpt_pkg::coord_diff(center_y, a_v.y);
            mul_req.a2 = prpt_pkg::coord_diff(b_v.y, a_v.y);
            mul_req.b2 = prpt_pkg::coord_diff(center_x, a_v.x);
          end
          default: begin
            mul_req.a1 = '0;
          end
        endcase
      end
      default: begin
        mem_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      total     <= '0;
      center_x  <= '0;
      center_y  <= '0;
      e         <= '0;
      step      <= '0;
      res_valid <= 1'b0;
    end else begin
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
      unique case (state)
        prpt_pkg::S_EXEC: begin
          e <= '0;
          if (cmd_r.action == prpt_pkg::ACT_CLEAR) begin
            center_x <= cmd_r.pos_x;
            center_y <= cmd_r.pos_y;
            total    <= '0;
          end else if (cmd_r.action == prpt_pkg::ACT_APPEND && room) begin
            total <= total + CNT_W'(1);
          end
        end
        prpt_pkg::S_ADV_YR: begin
          e <= e_inc;
        end
        prpt_pkg::S_ADV_CTR: begin
          center_x <= prpt_pkg::sat_coord({{(prpt_pkg::ROT_SUM_W - prpt_pkg::DIFF_W)
                                            {ox[prpt_pkg::DIFF_W-1]}}, ox});
          center_y <= prpt_pkg::sat_coord({{(prpt_pkg::ROT_SUM_W - prpt_pkg::DIFF_W)
                                            {oy[prpt_pkg::DIFF_W-1]}}, oy});
        end
        prpt_pkg::S_Q_EDGE: begin
          step <= '0;
          if (skip) begin
            e <= e_inc;
          end
        end
        prpt_pkg::S_Q_MUL: begin
          step <= step + prpt_pkg::STEP_W'(1);
          if (step == prpt_pkg::STEP_W'(5)) begin
            e <= e_inc;
          end
        end
        default: begin
          step <= step;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    unique case (state)
      prpt_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_r    <= cmd_item;
          inside_r <= 1'b0;
          status_r <= prpt_pkg::STAT_OK;
        end
      end
      prpt_pkg::S_EXEC: begin
        if (cmd_r.action == prpt_pkg::ACT_APPEND && !room) begin
          status_r <= prpt_pkg::STAT_FULL;
        end else if (cmd_r.action == prpt_pkg::ACT_QUERY && total == '0) begin
          status_r <= prpt_pkg::STAT_EMPTY;
        end
      end
      prpt_pkg::S_ADV_X: begin
        dx_r <= dx;
        dy_r <= dy;
      end
      prpt_pkg::S_ADV_XR: begin
        nx_r <= rot_sat;
      end
      prpt_pkg::S_Q_FIRST: begin
        first_v <= rd_v;
        a_v     <= rd_v;
      end
      prpt_pkg::S_Q_LOAD: begin
        b_v <= more ? rd_v : first_v;
      end
      prpt_pkg::S_Q_EDGE: begin
        acc <= '0;
        if (skip) begin
          a_v <= b_v;
        end
      end
      prpt_pkg::S_Q_MUL: begin
        if (step >= prpt_pkg::STEP_W'(2) && step <= prpt_pkg::STEP_W'(4)) begin
          acc <= acc + abs_res;
        end
        if (step == prpt_pkg::STEP_W'(5)) begin
          a_v <= b_v;
          if (hit) begin
            inside_r <= 1'b1;
          end
        end
      end
      prpt_pkg::S_FINISH: begin
        if (res_load) begin
          res_item.inside_res <= inside_r;
          res_item.count_now  <= cnt_ext[prpt_pkg::CNT_OUT_W-1:0];
          res_item.status     <= status_r;
        end
      end
      default: begin
        acc <= acc;
      end
    endcase
  end

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (cmd_valid && !cmd_stall) |=> cmd_stall)
    else $error("sequencer did not leave idle after accepting an item");

  a_result_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> ($past(state) == prpt_pkg::S_FINISH))
    else $error("result appeared without the sequencer finishing an item");

  a_rotate_addr: assert property (@(posedge clk) disable iff (rst)
    (mem_we && state == prpt_pkg::S_ADV_YR) |-> (e < total))
    else $error("rotated vertex written beyond the stored count");

  a_query_edge: assert property (@(posedge clk) disable iff (rst)
    (state == prpt_pkg::S_Q_MUL) |-> (e < total))
    else $error("query edge index beyond the stored count");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    (res_load && status_r == prpt_pkg::STAT_FULL) |-> (total == MAX_CNT))
    else $error("dropped append reported while the store had room");

endmodule

[sv/prpt_vertex_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpt_vertex_mem
// Single-port-write, single-port-read vertex store with a registered read.
// ----------------------------------------------------------------------------
module prpt_vertex_mem #(
  parameter int DEPTH = prpt_pkg::MAX_VERTICES_DEF,
  parameter int WIDTH = prpt_pkg::VERTEX_W
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/prpt_mul2.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// prpt_mul2
// Shared arithmetic unit: two signed products registered, then their sum or
// difference registered.
// ----------------------------------------------------------------------------
module prpt_mul2 (
  input  logic                                 clk,
  input  prpt_pkg::mul_req_t                   req,
  output logic signed [prpt_pkg::COMB_W-1:0]   res
);

  logic signed [prpt_pkg::PROD_W-1:0] p1;
  logic signed [prpt_pkg::PROD_W-1:0] p2;
  prpt_pkg::mul_op_t                  op_r;

  always_ff @(posedge clk) begin
    p1   <= $signed(req.a1) * $signed(req.b1);
    p2   <= $signed(req.a2) * $signed(req.b2);
    op_r <= req.op;
  end

  always_ff @(posedge clk) begin
    if (op_r == prpt_pkg::MUL_ADD) begin
      res <= {p1[prpt_pkg::PROD_W-1], p1} + {p2[prpt_pkg::PROD_W-1], p2};
    end else begin
      res <= {p1[prpt_pkg::PROD_W-1], p1} - {p2[prpt_pkg::PROD_W-1], p2};
    end
  end

endmodule

[sim/tb_polygon_rotate_and_point_test_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_polygon_rotate_and_point_test_core
// Self-checking bench for the polygon rotate and point test core.
// ----------------------------------------------------------------------------
// A directed table covers the empty, single-vertex, degenerate-edge,
// collinear, full-store and extreme-coordinate cases. Random clear, append,
// advance and query runs follow under several rotation and step settings
// and several idle patterns. One stretch holds the result side off long
// enough to back the core up. Results are checked against a directed row's
// own expected result, if given, else a behavioral store model in the bench.
// ----------------------------------------------------------------------------
module tb_polygon_rotate_and_point_test_core;

  localparam int     NV          = prpt_pkg::MAX_VERTICES_DEF;
  localparam longint C_HI        = 524287;
  localparam longint C_LO        = -524288;
  localparam int     QUIET_LIMIT = 4000;
  localparam int     HOLD_LEN    = 400;
  localparam int     TAIL_CYCLES = 200;
  localparam int     DIR_N       = 25;

  typedef struct packed {
    prpt_pkg::cmd_item_t cmd;
    logic                chk;
    prpt_pkg::res_item_t want;
  } dir_row_t;

  localparam prpt_pkg::res_item_t NO_RES = '{1'b0, 5'd0, prpt_pkg::STAT_OK};

  localparam dir_row_t DIR_ROWS [DIR_N] = '{
    '{'{prpt_pkg::ACT_QUERY,   20'sd0, 20'sd0},
      1'b1, '{1'b0, 5'd0,  prpt_pkg::STAT_EMPTY}},
    '{'{prpt_pkg::ACT_ADVANCE, 20'sd0, 20'sd0},
      1'b1, '{1'b0, 5'd0,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  prpt_pkg::COORD_MIN, prpt_pkg::COORD_MIN},
      1'b1, '{1'b0, 5'd1,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_QUERY,   20'sd0, 20'sd0},
      1'b1, '{1'b0, 5'd1,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  prpt_pkg::COORD_MAX, prpt_pkg::COORD_MIN},
      1'b1, '{1'b0, 5'd2,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  prpt_pkg::COORD_MAX, prpt_pkg::COORD_MAX},
      1'b1, '{1'b0, 5'd3,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  prpt_pkg::COORD_MAX, prpt_pkg::COORD_MAX},
      1'b1, '{1'b0, 5'd4,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  prpt_pkg::COORD_MIN, prpt_pkg::COORD_MAX},
      1'b1, '{1'b0, 5'd5,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_QUERY,   20'sd0, 20'sd0},
      1'b0, NO_RES},
    '{'{prpt_pkg::ACT_QUERY,   prpt_pkg::COORD_MIN, prpt_pkg::COORD_MIN},
      1'b0, NO_RES},
    '{'{prpt_pkg::ACT_APPEND,  20'sd0, 20'sd0},
      1'b1, '{1'b0, 5'd6,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd160, 20'sd160},
      1'b1, '{1'b0, 5'd7,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd320, 20'sd320},
      1'b1, '{1'b0, 5'd8,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_QUERY,   20'sd240, 20'sd240},
      1'b0, NO_RES},
    '{'{prpt_pkg::ACT_APPEND,  -20'sd16, 20'sd5},
      1'b1, '{1'b0, 5'd9,  prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd12345, -20'sd54321},
      1'b1, '{1'b0, 5'd10, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  -20'sd300000, 20'sd200000},
      1'b1, '{1'b0, 5'd11, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd77, -20'sd77},
      1'b1, '{1'b0, 5'd12, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd1, 20'sd0},
      1'b1, '{1'b0, 5'd13, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd0, -20'sd1},
      1'b1, '{1'b0, 5'd14, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  -20'sd524287, 20'sd3},
      1'b1, '{1'b0, 5'd15, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd4096, 20'sd4096},
      1'b1, '{1'b0, 5'd16, prpt_pkg::STAT_OK}},
    '{'{prpt_pkg::ACT_APPEND,  20'sd5, 20'sd5},
      1'b1, '{1'b0, 5'd16, prpt_pkg::STAT_FULL}},
    '{'{prpt_pkg::ACT_ADVANCE, 20'sd0, 20'sd0},
      1'b0, NO_RES},
    '{'{prpt_pkg::ACT_CLEAR,   prpt_pkg::COORD_MAX, prpt_pkg::COORD_MIN},
      1'b1, '{1'b0, 5'd0,  prpt_pkg::STAT_OK}}
  };

  logic                            clk;
  logic                            rst       = 1'b1;
  logic                            cmd_valid = 1'b0;
  logic                            cmd_stall;
  prpt_pkg::cmd_item_t             cmd_item  = '0;
  logic                            res_valid;
  logic                            res_stall = 1'b0;
  prpt_pkg::res_item_t             res_item;
  logic                            cfg_we    = 1'b0;
  prpt_pkg::cfg_idx_t              cfg_index = prpt_pkg::CFG_ROT_COS;
  logic [prpt_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  longint poly_x [NV];
  longint poly_y [NV];
  int     poly_count = 0;
  longint ctr_x      = 0;
  longint ctr_y      = 0;
  longint k_cos      = 16384;
  longint k_sin      = 0;
  longint k_stx      = 0;
  longint k_sty      = 0;

  prpt_pkg::res_item_t pending_results[$];
  int        err_count      = 0;
  int        quiet_cycles   = 0;
  int        send_gap_pct   = 0;
  int        recv_stall_pct = 0;
  logic      hold_toggle    = 1'b0;
  logic      hold_seen      = 1'b0;
  int        hold_left      = 0;

  polygon_rotate_and_point_test_core dut (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_stall (cmd_stall),
    .cmd_item  (cmd_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint clamp_coord(input longint v);
    if (v > C_HI) begin
      return C_HI;
    end
    if (v < C_LO) begin
      return C_LO;
    end
    return v;
  endfunction

  function automatic longint rand_coord();
    logic signed [prpt_pkg::COORD_W-1:0] v;
    v = prpt_pkg::COORD_W'($urandom);
    return longint'(v);
  endfunction

  function automatic longint near_coord(input longint base, input int unsigned rad);
    return clamp_coord(base + longint'($urandom_range(2 * rad)) - longint'(rad));
  endfunction

  function automatic longint fan_area2(input longint ax, input longint ay,
                                       input longint bx, input longint by,
                                       input longint qx, input longint qy);
    longint c;
    c = (bx - ax) * (qy - ay) - (by - ay) * (qx - ax);
    return (c < 0) ? -c : c;
  endfunction

  function automatic prpt_pkg::res_item_t apply_to_polygon(input prpt_pkg::cmd_item_t it);
    prpt_pkg::res_item_t r;
    longint    px, py, ox, oy, dx, dy, nx, ny, sub, whole;
    longint    half, unit;
    int        j;
    r    = '0;
    px   = longint'(it.pos_x);
    py   = longint'(it.pos_y);
    half = longint'(1) << (prpt_pkg::TRIG_SHIFT - 1);
    unit = longint'(1) << prpt_pkg::AREA_SHIFT;
    case (it.action)
      prpt_pkg::ACT_CLEAR: begin
        ctr_x      = px;
        ctr_y      = py;
        poly_count = 0;
      end
      prpt_pkg::ACT_APPEND: begin
        if (poly_count < NV) begin
          poly_x[poly_count] = px;
          poly_y[poly_count] = py;
          poly_count++;
        end else begin
          r.status = prpt_pkg::STAT_FULL;
        end
      end
      prpt_pkg::ACT_ADVANCE: begin
        ox = ctr_x + k_stx;
        oy = ctr_y + k_sty;
        for (int i = 0; i < poly_count; i++) begin
          dx = poly_x[i] - ctr_x;
          dy = poly_y[i] - ctr_y;
          nx = (dx * k_cos - dy * k_sin + half) >>> prpt_pkg::TRIG_SHIFT;
          ny = (dx * k_sin + dy * k_cos + half) >>> prpt_pkg::TRIG_SHIFT;
          poly_x[i] = clamp_coord(nx + ox);
          poly_y[i] = clamp_coord(ny + oy);
        end
        ctr_x = clamp_coord(ox);
        ctr_y = clamp_coord(oy);
      end
      default: begin
        if (poly_count == 0) begin
          r.status = prpt_pkg::STAT_EMPTY;
        end else begin
          for (int i = 0; i < poly_count; i++) begin
            j = (i + 1 < poly_count) ? i + 1 : 0;
            if (poly_x[i] == poly_x[j] && poly_y[i] == poly_y[j]) begin
              continue;
            end
            sub = fan_area2(px, py, poly_x[i], poly_y[i], poly_x[j], poly_y[j])
                + fan_area2(px, py, poly_x[j], poly_y[j], ctr_x, ctr_y)
                + fan_area2(px, py, poly_x[i], poly_y[i], ctr_x, ctr_y);
            whole = fan_area2(poly_x[i], poly_y[i], poly_x[j], poly_y[j], ctr_x, ctr_y);
            if (sub / unit == whole / unit) begin
              r.inside_res = 1'b1;
              break;
            end
          end
        end
      end
    endcase
    r.count_now = prpt_pkg::CNT_OUT_W'(poly_count);
    return r;
  endfunction

  function automatic void note_error(input string msg);
    err_count++;
    if (err_count <= 10) begin
      $display("%s", msg);
    end
  endfunction

  task automatic send_cmd(input prpt_pkg::act_t act, input longint px, input longint py,
                          input logic typed, input prpt_pkg::res_item_t typed_res);
    prpt_pkg::cmd_item_t it;
    prpt_pkg::res_item_t exp_r;
    it.action = act;
    it.pos_x  = prpt_pkg::COORD_W'(px);
    it.pos_y  = prpt_pkg::COORD_W'(py);
    while ($urandom_range(99) < send_gap_pct) begin
      cmd_valid <= 1'b0;
      @(posedge clk);
    end
    cmd_valid <= 1'b1;
    cmd_item  <= it;
    @(posedge clk);
    while (cmd_stall) begin
      @(posedge clk);
    end
    exp_r = apply_to_polygon(it);
    if (typed) begin
      exp_r = typed_res;
    end
    pending_results.insert(pending_results.size(), exp_r);
  endtask

  task automatic send_op(input prpt_pkg::act_t act, input longint px, input longint py);
    send_cmd(act, px, py, 1'b0, NO_RES);
  endtask

  task automatic wait_idle();
    cmd_valid <= 1'b0;
    while (pending_results.size() != 0) begin
      @(posedge clk);
    end
  endtask

  task automatic set_config(input longint c, input longint s,
                            input longint sx, input longint sy);
    cfg_we    <= 1'b1;
    cfg_index <= prpt_pkg::CFG_ROT_COS;
    cfg_wdata <= prpt_pkg::CFG_DATA_W'(c);
    @(posedge clk);
    cfg_index <= prpt_pkg::CFG_ROT_SIN;
    cfg_wdata <= prpt_pkg::CFG_DATA_W'(s);
    @(posedge clk);
    cfg_index <= prpt_pkg::CFG_STEP_X;
    cfg_wdata <= prpt_pkg::CFG_DATA_W'(sx);
    @(posedge clk);
    cfg_index <= prpt_pkg::CFG_STEP_Y;
    cfg_wdata <= prpt_pkg::CFG_DATA_W'(sy);
    @(posedge clk);
    cfg_we <= 1'b0;
    k_cos = c;
    k_sin = s;
    k_stx = sx;
    k_sty = sy;
  endtask

  task automatic set_idle(input int mode);
    case (mode)
      0: begin
        send_gap_pct = 0;
        recv_stall_pct <= 0;
      end
      1: begin
        send_gap_pct = 60;
        recv_stall_pct <= 0;
      end
      2: begin
        send_gap_pct = 0;
        recv_stall_pct <= 60;
      end
      default: begin
        send_gap_pct = 17;
        recv_stall_pct <= 17;
      end
    endcase
  endtask

  // Mostly well-formed shapes: a clear, a run of appends around the center,
  // then advances and queries near the shape. The rest is unstructured.
  task automatic run_shapes(input int n_items);
    int          sent, nv, ops, k, pick, vi;
    int unsigned rad;
    longint      cx, cy, vx, vy;
    sent = 0;
    vx   = 0;
    vy   = 0;
    while (sent < n_items) begin
      if ($urandom_range(99) < 12) begin
        send_op(prpt_pkg::act_t'($urandom_range(3)), rand_coord(), rand_coord());
        sent++;
      end else begin
        case ($urandom_range(3))
          0:       rad = 48;
          1:       rad = 1024;
          2:       rad = 32768;
          default: rad = 524287;
        endcase
        if ($urandom_range(1) == 1) begin
          cx = near_coord(0, 4096);
          cy = near_coord(0, 4096);
        end else begin
          cx = rand_coord();
          cy = rand_coord();
        end
        send_op(prpt_pkg::ACT_CLEAR, cx, cy);
        nv = ($urandom_range(7) == 0) ? $urandom_range(16, 20) : $urandom_range(1, 12);
        for (k = 0; k < nv; k++) begin
          if (k == 0 || $urandom_range(7) != 0) begin
            vx = near_coord(cx, rad);
            vy = near_coord(cy, rad);
          end
          send_op(prpt_pkg::ACT_APPEND, vx, vy);
        end
        ops = $urandom_range(2, 10);
        for (k = 0; k < ops; k++) begin
          pick = $urandom_range(99);
          if (pick < 20) begin
            send_op(prpt_pkg::ACT_ADVANCE, rand_coord(), rand_coord());
          end else if (pick < 30 && poly_count > 0) begin
            vi = $urandom_range(poly_count - 1);
            send_op(prpt_pkg::ACT_QUERY, poly_x[vi], poly_y[vi]);
          end else begin
            send_op(prpt_pkg::ACT_QUERY, near_coord(ctr_x, rad + rad / 2),
                    near_coord(ctr_y, rad + rad / 2));
          end
        end
        sent += 1 + nv + ops;
      end
    end
  endtask

  always @(posedge clk) begin
    prpt_pkg::res_item_t want;
    if (res_valid && !res_stall) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result: inside=%0d count=%0d status=%0d",
                             res_item.inside_res, res_item.count_now, res_item.status));
      end else begin
        want = pending_results.pop_front();
        if (res_item.inside_res !== want.inside_res ||
            res_item.count_now !== want.count_now ||
            res_item.status !== want.status) begin
          note_error($sformatf(
            "mismatch: expected inside=%0d count=%0d status=%0d, got inside=%0d count=%0d status=%0d",
            want.inside_res, want.count_now, want.status,
            res_item.inside_res, res_item.count_now, res_item.status));
        end
      end
    end
    if (hold_toggle != hold_seen) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_LEN;
      res_stall <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      res_stall <= 1'b1;
    end else begin
      res_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_valid && !cmd_stall) || (res_valid && !res_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int ph;
    int k;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    for (k = 0; k < DIR_N; k++) begin
      send_cmd(DIR_ROWS[k].cmd.action, longint'(DIR_ROWS[k].cmd.pos_x),
               longint'(DIR_ROWS[k].cmd.pos_y), DIR_ROWS[k].chk, DIR_ROWS[k].want);
    end

    for (ph = 0; ph < 6; ph++) begin
      wait_idle();
      case (ph)
        0: set_config(16384, 0, 0, 0);
        1: set_config(0, 16384, C_HI, C_HI);
        2: set_config(-16384, -16384, C_LO, C_LO);
        3: set_config(16305, 1606, 37, -21);
        4: set_config(longint'($urandom_range(32768)) - 16384,
                      longint'($urandom_range(32768)) - 16384,
                      near_coord(0, 2048), near_coord(0, 2048));
        default: set_config(16384, -16384, rand_coord(), rand_coord());
      endcase
      set_idle(ph % 4);
      run_shapes(175);
    end

    // Hold the result side off while items keep coming so the core backs up.
    wait_idle();
    set_config(16384, 0, 16, -16);
    set_idle(0);
    hold_toggle <= ~hold_toggle;
    send_op(prpt_pkg::ACT_CLEAR, 0, 0);
    for (k = 0; k < 6; k++) begin
      send_op(prpt_pkg::ACT_APPEND, near_coord(0, 2048), near_coord(0, 2048));
    end
    for (k = 0; k < 12; k++) begin
      if (k % 3 == 0) begin
        send_op(prpt_pkg::ACT_ADVANCE, rand_coord(), rand_coord());
      end else begin
        send_op(prpt_pkg::ACT_QUERY, near_coord(ctr_x, 3072), near_coord(ctr_y, 3072));
      end
    end

    wait_idle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (pending_results.size() != 0) begin
      note_error($sformatf("%0d results never arrived", pending_results.size()));
    end
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
